### design/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg: shared definitions for the sorted array table
// Sizes, transaction payload types, operation and status codes, and the
// command and neighbor link types that run along the chain of cells.
// ----------------------------------------------------------------------------
package sat_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 256;
   localparam int VALUE_WIDTH = 32;
   localparam int INDEX_WIDTH = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam int POS_WIDTH   = 8;
   localparam int CAP_WIDTH   = 9;
   localparam int CMP_WIDTH   = (INDEX_WIDTH > POS_WIDTH) ? INDEX_WIDTH : POS_WIDTH;

   // Read tree geometry: the cells are read in groups, one register per group.
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_COUNT = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [POS_WIDTH-1:0]   pos_type;
   typedef logic [CMP_WIDTH-1:0]   cmp_type;
   typedef logic [CAP_WIDTH-1:0]   cap_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Input transaction.
   typedef struct packed {
      op_type      operation;
      logic [31:0] item_value;
      pos_type     position;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [31:0] read_value;
      logic [8:0]  entry_count;
      status_type  status;
   } rsp_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic      insert_en;
      logic      remove_en;
      logic      clear_en;
      value_type item;
      pos_type   pos;
   } cell_cmd_type;

   // What a cell shows to its neighbors.
   typedef struct packed {
      logic      valid;
      logic      lt;
      value_type value;
   } cell_link_type;

endpackage

### design/sat_cell.sv
// ----------------------------------------------------------------------------
// sat_cell: one entry of the sorted array table
// Holds one value and its valid bit. On insert it keeps its value, takes the
// new value or its lower neighbor's; at or above a remove position it takes
// its upper neighbor's. It drives its value to the read tree when selected.
// ----------------------------------------------------------------------------
module sat_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sat_pkg::index_type    cell_index,
   input  sat_pkg::cell_cmd_type cmd,
   input  sat_pkg::cell_link_type lower_link,
   input  sat_pkg::cell_link_type upper_link,
   output sat_pkg::cell_link_type own_link,
   output sat_pkg::value_type    hit_value
);

   logic               valid_ff;
   logic               valid_in;
   sat_pkg::value_type value_ff;
   sat_pkg::value_type value_in;
   logic               lt;
   logic               at_or_above_pos;
   logic               at_pos;

   // The entry is below the new value, so the new value lands further up.
   assign lt = valid_ff && (value_ff < cmd.item);

   assign at_or_above_pos = sat_pkg::cmp_type'(cell_index) >= sat_pkg::cmp_type'(cmd.pos);
   assign at_pos          = sat_pkg::cmp_type'(cell_index) == sat_pkg::cmp_type'(cmd.pos);

   assign own_link.valid = valid_ff;
   assign own_link.lt    = lt;
   assign own_link.value = value_ff;

   // Selected entry for the read tree; all others contribute zero.
   assign hit_value = at_pos ? value_ff : '0;

   // Next value and valid bit from the broadcast command.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.clear_en) begin
         valid_in = 1'b0;
      end else if (cmd.insert_en) begin
         if (!lt) begin
            value_in = lower_link.lt ? cmd.item : lower_link.value;
            valid_in = valid_ff | lower_link.valid;
         end
      end else if (cmd.remove_en) begin
         if (at_or_above_pos) begin
            value_in = upper_link.value;
            valid_in = upper_link.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### design/sat_read_tree.sv
// ----------------------------------------------------------------------------
// sat_read_tree: registered OR tree that reads the selected cell
// Each group of cells is reduced into a register; the group registers are
// then reduced into one value in the following cycle.
// ----------------------------------------------------------------------------
module sat_read_tree (
   input  logic               clock,
   input  sat_pkg::value_type hit_values [sat_pkg::TABLE_DEPTH],
   output sat_pkg::value_type read_value
);

   sat_pkg::value_type group_ff [sat_pkg::GROUP_COUNT];
   sat_pkg::value_type group_in [sat_pkg::GROUP_COUNT];

   // First level: one OR per group of cells.
   for (genvar g = 0; g < sat_pkg::GROUP_COUNT; g++) begin : g_group
      always_comb begin
         group_in[g] = '0;
         for (int k = 0; k < sat_pkg::GROUP_SIZE; k++) begin
            if (g * sat_pkg::GROUP_SIZE + k < sat_pkg::TABLE_DEPTH) begin
               group_in[g] = group_in[g] | hit_values[g * sat_pkg::GROUP_SIZE + k];
            end
         end
      end

      always_ff @(posedge clock) begin
         group_ff[g] <= group_in[g];
      end
   end

   // Second level: OR of the group registers.
   always_comb begin
      read_value = '0;
      for (int g = 0; g < sat_pkg::GROUP_COUNT; g++) begin
         read_value = read_value | group_ff[g];
      end
   end

endmodule

### design/sorted_array_table.sv
// ----------------------------------------------------------------------------
// sorted_array_table: table of values kept in ascending unsigned order
// A chain of cells, one per entry, performs insert and remove; lookup reads
// the selected cell through a registered OR tree.
//
//   Channel   Ports                          Transfer
//   request   start, busy, req_payload       start high and busy low
//   result    rsp_strobe, rsp_payload        one cycle, cannot be held off
//   config    csr_valid, csr_ready, csr_data csr_valid and csr_ready high
//
// Insert, remove and clear show their result in the next cycle, and a new
// transaction may be accepted in that same cycle.
// Lookup: busy is high for one cycle while the read tree register fills,
// then the result shows.
// Reset clears the count and every cell's valid bit at once; no clearing pass.
// The receiver cannot stall; the configuration port is always ready.
// ----------------------------------------------------------------------------
module sorted_array_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sat_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output sat_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  sat_pkg::cap_type csr_data
);

   sat_pkg::cap_type        capacity_ff;
   sat_pkg::count_type      count_ff;
   sat_pkg::count_type      count_in;
   logic                    lookup_pending_ff;
   logic                    lookup_pending_in;
   sat_pkg::status_type     lookup_status_ff;
   sat_pkg::status_type     lookup_status_in;
   logic                    rsp_strobe_ff;
   logic                    rsp_strobe_in;
   sat_pkg::rsp_type        rsp_payload_ff;
   sat_pkg::rsp_type        rsp_payload_in;

   logic                    accept;
   logic                    full;
   logic                    in_range;
   sat_pkg::status_type     op_status;
   sat_pkg::cell_cmd_type   cmd;
   sat_pkg::cell_link_type  links [sat_pkg::TABLE_DEPTH];
   sat_pkg::value_type      hit_values [sat_pkg::TABLE_DEPTH];
   sat_pkg::value_type      tree_value;

   assign csr_ready = 1'b1;
   assign busy      = lookup_pending_ff;
   assign accept    = start && !busy;

   // Limit checks against the current count.
   assign full     = (32'(count_ff) >= 32'(capacity_ff)) ||
                     (32'(count_ff) >= 32'(sat_pkg::TABLE_DEPTH));
   assign in_range = 32'(req_payload.position) < 32'(count_ff);

   // Command broadcast to the chain.
   always_comb begin
      cmd.insert_en = accept && (req_payload.operation == sat_pkg::OP_INSERT) && !full;
      cmd.remove_en = accept && (req_payload.operation == sat_pkg::OP_REMOVE) && in_range;
      cmd.clear_en  = accept && (req_payload.operation == sat_pkg::OP_CLEAR);
      cmd.item      = sat_pkg::value_type'(req_payload.item_value);
      cmd.pos       = req_payload.position;
   end

   // Chain of cells; the ends are tied so the edge cells need no special case.
   for (genvar i = 0; i < sat_pkg::TABLE_DEPTH; i++) begin : g_cell
      sat_pkg::cell_link_type lower_link;
      sat_pkg::cell_link_type upper_link;

      if (i == 0) begin : g_bottom
         assign lower_link.valid = 1'b1;
         assign lower_link.lt    = 1'b0;
         assign lower_link.value = cmd.item;
      end else begin : g_lower
         assign lower_link = links[i-1];
      end

      if (i == sat_pkg::TABLE_DEPTH - 1) begin : g_top
         assign upper_link.valid = 1'b0;
         assign upper_link.lt    = 1'b0;
         assign upper_link.value = links[i].value;
      end else begin : g_upper
         assign upper_link = links[i+1];
      end

      sat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (sat_pkg::index_type'(i)),
         .cmd        (cmd),
         .lower_link (lower_link),
         .upper_link (upper_link),
         .own_link   (links[i]),
         .hit_value  (hit_values[i])
      );
   end

   sat_read_tree u_read_tree (
      .clock      (clock),
      .hit_values (hit_values),
      .read_value (tree_value)
   );

   // Count update and status of the accepted operation.
   always_comb begin
      count_in  = count_ff;
      op_status = sat_pkg::STATUS_OK;
      case (req_payload.operation)
         sat_pkg::OP_INSERT: begin
            if (full) begin
               op_status = sat_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + sat_pkg::count_type'(1);
            end
         end
         sat_pkg::OP_LOOKUP: begin
            if (!in_range) begin
               op_status = sat_pkg::STATUS_RANGE;
            end
         end
         sat_pkg::OP_REMOVE: begin
            if (in_range) begin
               count_in = count_ff - sat_pkg::count_type'(1);
            end else begin
               op_status = sat_pkg::STATUS_RANGE;
            end
         end
         sat_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Result register: immediate operations now, a lookup in the cycle after it is accepted.
   always_comb begin
      lookup_pending_in = 1'b0;
      lookup_status_in  = lookup_status_ff;
      rsp_strobe_in     = 1'b0;
      rsp_payload_in    = rsp_payload_ff;
      if (lookup_pending_ff) begin
         rsp_strobe_in              = 1'b1;
         rsp_payload_in.read_value  = (lookup_status_ff == sat_pkg::STATUS_OK) ?
                                      32'(tree_value) : 32'd0;
         rsp_payload_in.entry_count = 9'(count_ff);
         rsp_payload_in.status      = lookup_status_ff;
      end else if (accept) begin
         if (req_payload.operation == sat_pkg::OP_LOOKUP) begin
            lookup_pending_in = 1'b1;
            lookup_status_in  = op_status;
         end else begin
            rsp_strobe_in              = 1'b1;
            rsp_payload_in.read_value  = 32'd0;
            rsp_payload_in.entry_count = 9'(count_in);
            rsp_payload_in.status      = op_status;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff          <= '0;
         capacity_ff       <= sat_pkg::cap_type'(256);
         lookup_pending_ff <= 1'b0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         lookup_pending_ff <= lookup_pending_in;
         rsp_strobe_ff     <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lookup_status_ff <= lookup_status_in;
      rsp_payload_ff   <= rsp_payload_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### design/sat_checker.sv
// ----------------------------------------------------------------------------
// sat_checker: port level checks for the sorted array table
// Watches the request, result and busy ports over time.
// ----------------------------------------------------------------------------
module sat_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input sat_pkg::req_type req_payload,
   input logic             rsp_strobe,
   input sat_pkg::rsp_type rsp_payload
);

   // Busy only follows an accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> $past(start && !busy))
      else $error("busy without a preceding accepted transaction");

   // Every accepted transaction gives a result or starts a lookup.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted transaction gave no result and no lookup");

   // A busy cycle is followed by the lookup result with busy low.
   assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("lookup did not complete after its busy cycle");

   // Failed operations return zero data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.status != sat_pkg::STATUS_OK)) |->
         (rsp_payload.read_value == 32'd0))
      else $error("nonzero read value on a failed operation");

   // The count never exceeds the table depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_payload.entry_count) <= 32'(sat_pkg::TABLE_DEPTH)))
      else $error("entry count beyond table depth");

endmodule

bind sorted_array_table sat_checker u_sat_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
